// File: hdl/bcl_pkg.sv
`default_nettype none
package bcl_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OUT_IDX_W = 6;

    typedef struct packed {
        logic        operation;
        logic [31:0] block_number;
    } t_in;

    typedef struct packed {
        logic                 status;
        logic                 hit;
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 writeback_needed;
        logic [31:0]          victim_block_number;
        logic                 fetch_needed;
    } t_out;

    typedef struct packed {
        logic [31:0] tag;
        logic        dirty;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_BLOCK = 1'b1;

    typedef struct packed {
        logic valid;
    } t_res_hs;

    function automatic logic [OUT_IDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, idx};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/bcl_ram.sv
`default_nettype none
module bcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/bcl_ctrl.sv
`default_nettype none
module bcl_ctrl
    import bcl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_in     i_in,
    output t_res_hs      o_hs,
    input  wire logic    i_res_take,
    output t_out         o_res
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_TAIL   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_vld;
    logic [31:0]        r_clock;

    logic               r_op;
    logic [31:0]        r_blk;
    logic               r_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_hit_dirty;
    logic [31:0]        r_best;
    logic [IDX_W-1:0]   r_vic_idx;
    logic [31:0]        r_vic_tag;
    logic               r_vic_dirty;
    t_out               r_res;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    t_entry             ram_rdata;
    logic               in_acc;
    logic               miss_wb;
    t_out               acc_res;

    bcl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign o_hs.valid = (r_state == ST_DONE);
    assign o_res      = r_res;
    assign ram_re     = (r_state == ST_SCAN);
    assign miss_wb    = !r_found && r_vic_dirty;

    always_comb begin
        acc_res        = '0;
        acc_res.status = (i_in.block_number == 32'd0) ? STATUS_BAD_BLOCK : STATUS_OK;
    end

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_clr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.block_number == 32'd0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                ram_we             = 1'b1;
                ram_waddr          = r_found ? r_hit_idx : r_vic_idx;
                ram_wdata.tag      = r_blk;
                ram_wdata.dirty    = r_found ? (r_hit_dirty || (r_op == OP_WRITE))
                                             : (r_op == OP_WRITE);
                ram_wdata.stamp    = r_clock;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_rd_vld <= 1'b0;
            r_clock  <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == ST_UPDATE) begin
                r_clock <= r_clock + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in.operation;
            r_blk  <= i_in.block_number;
            r_addr <= '0;
            r_res  <= acc_res;
        end
        if (r_state == ST_SCAN) begin
            r_addr   <= r_addr + 1'b1;
            r_rd_idx <= r_addr;
        end
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_found     <= (ram_rdata.tag == r_blk);
                r_hit_idx   <= '0;
                r_hit_dirty <= ram_rdata.dirty;
                r_best      <= ram_rdata.stamp;
                r_vic_idx   <= '0;
                r_vic_tag   <= ram_rdata.tag;
                r_vic_dirty <= ram_rdata.dirty;
            end else begin
                if (!r_found && (ram_rdata.tag == r_blk)) begin
                    r_found     <= 1'b1;
                    r_hit_idx   <= r_rd_idx;
                    r_hit_dirty <= ram_rdata.dirty;
                end
                if (ram_rdata.stamp < r_best) begin
                    r_best      <= ram_rdata.stamp;
                    r_vic_idx   <= r_rd_idx;
                    r_vic_tag   <= ram_rdata.tag;
                    r_vic_dirty <= ram_rdata.dirty;
                end
            end
        end
        if (r_state == ST_UPDATE) begin
            r_res.status              <= STATUS_OK;
            r_res.hit                 <= r_found;
            r_res.entry_index         <= idx_to_out(r_found ? r_hit_idx : r_vic_idx);
            r_res.writeback_needed    <= miss_wb;
            r_res.victim_block_number <= miss_wb ? r_vic_tag : 32'd0;
            r_res.fetch_needed        <= !r_found && (r_op == OP_READ);
        end
    end

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_TAIL) |-> !ram_we)
        else $error("entry write during tag scan");
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_clock == 32'($past(r_clock) + 32'd1)))
        else $error("use clock did not advance on update");
    a_scan_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TAIL) |-> r_rd_vld && (r_rd_idx == LAST_IDX))
        else $error("scan ended before the last entry was compared");
    a_take_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_take |-> (r_state == ST_DONE))
        else $error("result taken while none is pending");
`endif

endmodule
`default_nettype wire

// File: hdl/block_cache_lru_directory_top.sv
// Tag and LRU policy engine of a fully associative write-back block cache.
// Each request is a read or write of one block number and returns one result beat.
// All tag, dirty and use-time state sits in one synchronous RAM of ENTRIES words;
// every request for a nonzero block scans the whole RAM once, one word a cycle,
// then writes one entry back; a request for block zero skips the scan and
// returns a bad-block status. After reset the RAM is cleared one entry a cycle,
// so input is stalled until the clear has finished.
// The result sits in an output register, so the next request is taken while a
// finished result still waits downstream.
`default_nettype none
module block_cache_lru_directory_top
    import bcl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    t_res_hs hs;
    t_out    res;
    logic    res_take;
    logic    r_out_valid;
    t_out    r_out;

    bcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_hs       (hs),
        .i_res_take (res_take),
        .o_res      (res)
    );

    assign res_take    = hs.valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_out))
        else $error("stalled output beat changed");
    a_take_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> o_out_valid && (o_out == $past(res)))
        else $error("result beat lost on the way to the output register");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !res_take)
        else $error("pending output beat overwritten");
`endif

endmodule
`default_nettype wire
